// ===== hw/rtl/ssc_pkg.sv =====
package ssc_pkg;

	// Controller shape.
	localparam int ORDER    = 5;
	localparam int CHANNELS = 2;

	// Sizes of the coefficient tables that are actually populated.
	localparam int TAB_CH = 2;
	localparam int TAB_N  = 5;

	// Row 0 is C, rows 1..ORDER are the rows of A. Each row has ORDER state
	// terms and one error term (B).
	localparam int ROWS  = ORDER + 1;
	localparam int TERMS = ORDER + 1;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int TERM_W = $clog2(TERMS);

	localparam int COEF_W  = 32;
	localparam int STATE_W = 40;
	localparam int ERR_W   = 16;
	localparam int FORCE_W = 32;
	localparam int FRAC_SH = 20;
	localparam int ACC_W   = 76;
	localparam int RND_W   = ACC_W - FRAC_SH;

	typedef struct packed {
		logic                    op;
		logic signed [ERR_W-1:0] error;
	} cmd_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_res;
		logic                      saturated;
	} res_t;

	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [ROW_W-1:0] row;
	} mac_ctl_t;

	typedef struct packed {
		logic                    valid;
		logic [ROW_W-1:0]        row;
		logic signed [RND_W-1:0] value;
	} mac_res_t;

	localparam logic signed [COEF_W-1:0] MAT_A [TAB_CH][TAB_N][TAB_N] = '{
		'{
			'{ 32'sd1041026, -32'sd14261, 32'sd2517, -32'sd105, 32'sd1049 },
			'{ -32'sd14365, 32'sd1013763, 32'sd524, 32'sd0, -32'sd524 },
			'{ 32'sd2621, 32'sd1783, 32'sd1045850, 32'sd105, -32'sd3041 },
			'{ -32'sd315, -32'sd315, 32'sd105, 32'sd1048576, 32'sd2097 },
			'{ -32'sd11220, 32'sd2307, 32'sd14890, 32'sd1258, -32'sd105 }
		},
		'{
			'{ 32'sd1022676, -32'sd18455, -32'sd315, 32'sd0, 32'sd105 },
			'{ -32'sd21076, 32'sd1032952, 32'sd210, 32'sd0, -32'sd105 },
			'{ -32'sd4719, 32'sd419, 32'sd1044906, 32'sd210, 32'sd3460 },
			'{ 32'sd839, 32'sd210, 32'sd315, 32'sd1048576, -32'sd1049 },
			'{ -32'sd20447, 32'sd14890, -32'sd24746, 32'sd315, -32'sd105 }
		}
	};

	localparam logic signed [COEF_W-1:0] VEC_B [TAB_CH][TAB_N] = '{
		'{ 32'sd3985, 32'sd4928, 32'sd3146, -32'sd210, -32'sd17092 },
		'{ 32'sd14051, 32'sd3460, -32'sd12583, 32'sd1258, -32'sd77595 }
	};

	localparam logic signed [COEF_W-1:0] VEC_C [TAB_CH][TAB_N] = '{
		'{ 32'sd59245, -32'sd68157, -32'sd2522350, 32'sd2108896, -32'sd1059990798 },
		'{ 32'sd34288, -32'sd89234, 32'sd3401266, -32'sd1058433, -32'sd1030610118 }
	};

	// Coefficient for one (channel, row, term) slot; unpopulated slots read 0.
	function automatic logic signed [COEF_W-1:0] coef_lookup(
		input logic [CH_W-1:0]   ch,
		input logic [ROW_W-1:0]  row,
		input logic [TERM_W-1:0] term
	);
		int c;
		int r;
		int t;
		logic signed [COEF_W-1:0] v;
		c = int'(ch);
		r = int'(row);
		t = int'(term);
		v = '0;
		if (c < TAB_CH) begin
			if (r == 0) begin
				if (t < TAB_N) begin
					v = VEC_C[c][t];
				end
			end else if (r - 1 < TAB_N) begin
				if (t < ORDER) begin
					if (t < TAB_N) begin
						v = MAT_A[c][r-1][t];
					end
				end else if (t == ORDER) begin
					v = VEC_B[c][r-1];
				end
			end
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/ssc_if.sv =====
interface ssc_cmd_if;
	import ssc_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ssc_res_if;
	import ssc_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/ssc_mac.sv =====
module ssc_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ssc_pkg::mac_ctl_t                     ctl,
	input  logic signed [ssc_pkg::COEF_W-1:0]     coef,
	input  logic signed [ssc_pkg::STATE_W-1:0]    opnd,
	output ssc_pkg::mac_res_t                     res
);
	import ssc_pkg::*;

	localparam int XH_W = STATE_W - FRAC_SH;
	localparam int PH_W = COEF_W + XH_W;
	localparam int PL_W = COEF_W + FRAC_SH + 1;

	logic signed [XH_W-1:0]    xh;
	logic signed [FRAC_SH:0]   xl;
	logic signed [PH_W-1:0]    ph_s1;
	logic signed [PL_W-1:0]    pl_s1;
	mac_ctl_t                  ctl_s1;
	logic signed [ACC_W-1:0]   acc_s2;
	mac_ctl_t                  ctl_s2;
	logic signed [ACC_W-1:0]   acc_base;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [RND_W-1:0]   rnd_s3;
	logic                      vld_s3;
	logic [ROW_W-1:0]          row_s3;

	// The 40-bit operand is taken as a signed high part and an unsigned
	// 20-bit low part, so each product stays within a 32-bit-class multiplier.
	assign xh = opnd[STATE_W-1:FRAC_SH];
	assign xl = $signed({1'b0, opnd[FRAC_SH-1:0]});

	assign acc_base = ctl_s1.first ? '0 : acc_s2;
	assign acc_rnd  = acc_s2 + (ACC_W'(1) <<< (FRAC_SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			vld_s3 <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			vld_s3 <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1 <= coef * xh;
		pl_s1 <= coef * xl;
		if (ctl_s1.valid) begin
			acc_s2 <= acc_base + (ACC_W'(ph_s1) <<< FRAC_SH) + ACC_W'(pl_s1);
		end
		rnd_s3 <= acc_rnd[ACC_W-1:FRAC_SH];
		row_s3 <= ctl_s2.row;
	end

	assign res.valid = vld_s3;
	assign res.row   = row_s3;
	assign res.value = rnd_s3;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.valid && ctl.last) |-> ##3 res.valid)
		else $error("row end did not produce a result");

	a_result_from_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $past(ctl_s1.valid && ctl_s1.last, 2))
		else $error("result without a completed row");

	a_row_tag_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.valid && ctl.last) |-> ##3 (res.row == $past(ctl.row, 3)))
		else $error("row tag lost in the pipeline");

endmodule

// ===== hw/rtl/state_space_controller_step_top.sv =====
// An item's products are issued one per cycle into the single shared multiply-accumulate
// unit; they pass through the MAC pipeline, the last row is collected, and then the
// result is registered. The block takes no new item until it has finished the previous
// one, but a new item is taken while the previous result still waits. Reset (arst_n,
// asynchronous): state cleared to zero, ready right after.
module state_space_controller_step_top (
	input  logic      clk,
	input  logic      arst_n,
	ssc_cmd_if.sink   cmd,
	ssc_res_if.source res
);
	import ssc_pkg::*;

	// The sequencer walks rows, then terms within each row. Row 0 produces
	// the force output (C times x); rows 1..ORDER produce the new state
	// elements (a row of A times x plus B times the error). The error term
	// is fed to the MAC as a Q.16 operand, which is the error shifted left
	// by eight, so every term has the same scaling. New state elements are
	// parked in nx_q and committed together, because every row must still
	// see the state from before the update.
	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} seq_state_t;

	seq_state_t                  st_q;
	logic [CH_W-1:0]             ch_q;
	logic                        ch_ok_q;
	logic signed [ERR_W-1:0]     err_q;
	logic [ROW_W-1:0]            row_q;
	logic [TERM_W-1:0]           term_q;
	logic signed [STATE_W-1:0]   state_q [CHANNELS][ORDER];
	logic signed [STATE_W-1:0]   nx_q [ORDER];
	logic signed [FORCE_W-1:0]   force_q;
	logic                        sat_q;
	logic                        res_vld_q;
	res_t                        res_data_q;

	mac_ctl_t                    mac_ctl;
	mac_res_t                    mac_res;
	logic signed [COEF_W-1:0]    mac_coef;
	logic signed [STATE_W-1:0]   mac_opnd;

	logic                        row_end;
	logic                        last_row;
	logic                        out_free;
	logic [ROW_W-1:0]            res_rm1;
	logic                        f_clip;
	logic                        s_clip;
	logic signed [FORCE_W-1:0]   f_val;
	logic signed [STATE_W-1:0]   s_val;

	assign row_end  = (term_q == TERM_W'(TERMS - 1));
	assign last_row = (row_q == ROW_W'(ORDER));
	assign out_free = !res_vld_q || res.ready;

	// Issue side: one coefficient and one operand per cycle while running.
	always_comb begin
		mac_ctl.valid = (st_q == S_RUN);
		mac_ctl.first = (term_q == '0);
		mac_ctl.last  = row_end;
		mac_ctl.row   = row_q;
		mac_coef      = coef_lookup(ch_q, row_q, term_q);
		if (term_q < TERM_W'(ORDER)) begin
			mac_opnd = state_q[ch_q][term_q[IDX_W-1:0]];
		end else begin
			mac_opnd = {{(STATE_W - ERR_W - 8){err_q[ERR_W-1]}}, err_q, 8'h00};
		end
	end

	ssc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.opnd   (mac_opnd),
		.res    (mac_res)
	);

	// Saturation of a rounded row sum: it fits when all bits above the
	// target sign bit agree with it.
	always_comb begin
		f_clip  = !((&mac_res.value[RND_W-1:FORCE_W-1]) ||
			(~|mac_res.value[RND_W-1:FORCE_W-1]));
		s_clip  = !((&mac_res.value[RND_W-1:STATE_W-1]) ||
			(~|mac_res.value[RND_W-1:STATE_W-1]));
		f_val   = mac_res.value[FORCE_W-1:0];
		s_val   = mac_res.value[STATE_W-1:0];
		if (f_clip) begin
			f_val = mac_res.value[RND_W-1] ? {1'b1, {(FORCE_W-1){1'b0}}}
				: {1'b0, {(FORCE_W-1){1'b1}}};
		end
		if (s_clip) begin
			s_val = mac_res.value[RND_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
				: {1'b0, {(STATE_W-1){1'b1}}};
		end
		res_rm1 = mac_res.row - ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			res_vld_q  <= 1'b0;
			res_data_q <= '0;
			row_q      <= '0;
			term_q     <= '0;
			ch_q       <= '0;
			ch_ok_q    <= 1'b0;
			err_q      <= '0;
			force_q    <= '0;
			sat_q      <= 1'b0;
			for (int i = 0; i < ORDER; i++) begin
				nx_q[i] <= '0;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				for (int i = 0; i < ORDER; i++) begin
					state_q[c][i] <= '0;
				end
			end
		end else begin
			// The result register is loaded from the completion state and
			// otherwise released once the receiver has taken it.
			if (st_q == S_DONE && out_free) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (cmd.valid) begin
						ch_q    <= CH_W'(cmd.data.op);
						ch_ok_q <= (int'(cmd.data.op) < CHANNELS);
						err_q   <= cmd.data.error;
						row_q   <= '0;
						term_q  <= '0;
						force_q <= '0;
						sat_q   <= 1'b0;
						// A channel beyond the table skips all arithmetic and
						// answers zero with the state left alone.
						st_q    <= (int'(cmd.data.op) < CHANNELS) ? S_RUN : S_DONE;
					end
				end
				S_RUN, S_DRAIN: begin
					if (st_q == S_RUN) begin
						if (row_end) begin
							term_q <= '0;
							row_q  <= row_q + ROW_W'(1);
							if (last_row) begin
								st_q <= S_DRAIN;
							end
						end else begin
							term_q <= term_q + TERM_W'(1);
						end
					end
					if (mac_res.valid) begin
						if (mac_res.row == '0) begin
							force_q <= f_val;
							sat_q   <= sat_q | f_clip;
						end else begin
							nx_q[res_rm1[IDX_W-1:0]] <= s_val;
							sat_q <= sat_q | s_clip;
							if (mac_res.row == ROW_W'(ORDER)) begin
								st_q <= S_DONE;
							end
						end
					end
				end
				S_DONE: begin
					// Wait here only if the previous result is still unclaimed.
					if (out_free) begin
						res_data_q.force_res <= force_q;
						res_data_q.saturated <= sat_q;
						if (ch_ok_q) begin
							for (int i = 0; i < ORDER; i++) begin
								state_q[ch_q][i] <= nx_q[i];
							end
						end
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready = (st_q == S_IDLE);
	assign res.valid = res_vld_q;
	assign res.data  = res_data_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("item accepted while the block was still busy");

	a_mac_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.valid |-> (st_q == S_RUN || st_q == S_DRAIN))
		else $error("MAC result arrived outside a computation");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(st_q == S_DONE))
		else $error("result item raised outside the completion state");

endmodule

// ===== sim/state_space_controller_step_top_tb.sv =====
module state_space_controller_step_top_tb;
	import ssc_pkg::*;

	// Width that holds any sum of five 32x40-bit products without overflow.
	localparam int SUM_W = 80;

	localparam logic signed [SUM_W-1:0] ROUND_HALF = 80'sd524288;
	localparam logic signed [SUM_W-1:0] FORCE_HI   = 80'sd2147483647;
	localparam logic signed [SUM_W-1:0] FORCE_LO   = -80'sd2147483648;
	localparam logic signed [SUM_W-1:0] STATE_HI   = 80'sd549755813887;
	localparam logic signed [SUM_W-1:0] STATE_LO   = -80'sd549755813888;
	localparam logic signed [SUM_W-1:0] ERR_TO_Q16 = 80'sd256;

	localparam int ROUND_SHIFT = 20;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 100;
	localparam int RANDOM_ITEMS = 400;
	localparam int LONG_HOLD = 400;

	localparam logic YAW   = 1'b0;
	localparam logic DEPTH = 1'b1;

	// The controller's own coefficient tables, Q11.20, kept separate from the
	// design's copy so that a corrupted table in the design is caught.
	localparam logic signed [31:0] CTL_A [CHANNELS][ORDER][ORDER] = '{
		'{
			'{ 32'sd1041026, -32'sd14261, 32'sd2517, -32'sd105, 32'sd1049 },
			'{ -32'sd14365, 32'sd1013763, 32'sd524, 32'sd0, -32'sd524 },
			'{ 32'sd2621, 32'sd1783, 32'sd1045850, 32'sd105, -32'sd3041 },
			'{ -32'sd315, -32'sd315, 32'sd105, 32'sd1048576, 32'sd2097 },
			'{ -32'sd11220, 32'sd2307, 32'sd14890, 32'sd1258, -32'sd105 }
		},
		'{
			'{ 32'sd1022676, -32'sd18455, -32'sd315, 32'sd0, 32'sd105 },
			'{ -32'sd21076, 32'sd1032952, 32'sd210, 32'sd0, -32'sd105 },
			'{ -32'sd4719, 32'sd419, 32'sd1044906, 32'sd210, 32'sd3460 },
			'{ 32'sd839, 32'sd210, 32'sd315, 32'sd1048576, -32'sd1049 },
			'{ -32'sd20447, 32'sd14890, -32'sd24746, 32'sd315, -32'sd105 }
		}
	};

	localparam logic signed [31:0] CTL_B [CHANNELS][ORDER] = '{
		'{ 32'sd3985, 32'sd4928, 32'sd3146, -32'sd210, -32'sd17092 },
		'{ 32'sd14051, 32'sd3460, -32'sd12583, 32'sd1258, -32'sd77595 }
	};

	localparam logic signed [31:0] CTL_C [CHANNELS][ORDER] = '{
		'{ 32'sd59245, -32'sd68157, -32'sd2522350, 32'sd2108896, -32'sd1059990798 },
		'{ 32'sd34288, -32'sd89234, 32'sd3401266, -32'sd1058433, -32'sd1030610118 }
	};

	// One error sample waiting to be offered, with the idle cycles that
	// precede it and whether the sender must first see every result back.
	typedef struct {
		cmd_t cmd;
		int   gap;
		bit   drain_first;
	} queued_sample_t;

	logic clk;
	logic arst_n;

	ssc_cmd_if cmd_ch ();
	ssc_res_if res_ch ();

	state_space_controller_step_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	queued_sample_t queued_samples[$];
	res_t expected_forces[$];

	// Predicted controller state, Q23.16, one vector per channel.
	logic signed [STATE_W-1:0] ctl_state [CHANNELS][ORDER];

	int in_flight;
	int gap_count;
	int hold_count;
	int res_taken;
	bit long_hold_done;
	int quiet_cycles;
	int fail_count;
	int yaw_items;
	int depth_items;
	int results_checked;
	int saturated_seen;

	// Rounds a Q.36 sum to Q.16, half toward plus infinity.
	function automatic logic signed [SUM_W-1:0] round_q16(input logic signed [SUM_W-1:0] sum);
		return (sum + ROUND_HALF) >>> ROUND_SHIFT;
	endfunction

	// Produces the force for the current state of the selected channel, then
	// moves that channel's state one step forward with the new error sample.
	function automatic res_t advance_controller(input cmd_t sample);
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] rounded;
		logic signed [ERR_W-1:0] err_s;
		logic signed [STATE_W-1:0] next_x [ORDER];
		res_t outcome;
		int ch;
		int i;
		int j;
		ch = int'(sample.op);
		err_s = sample.error;
		outcome.saturated = 1'b0;

		sum = '0;
		for (j = 0; j < ORDER; j++) begin
			sum = sum + CTL_C[ch][j] * ctl_state[ch][j];
		end
		rounded = round_q16(sum);
		if (rounded > FORCE_HI) begin
			rounded = FORCE_HI;
			outcome.saturated = 1'b1;
		end else if (rounded < FORCE_LO) begin
			rounded = FORCE_LO;
			outcome.saturated = 1'b1;
		end
		outcome.force_res = rounded[FORCE_W-1:0];

		for (i = 0; i < ORDER; i++) begin
			sum = CTL_B[ch][i] * err_s * ERR_TO_Q16;
			for (j = 0; j < ORDER; j++) begin
				sum = sum + CTL_A[ch][i][j] * ctl_state[ch][j];
			end
			rounded = round_q16(sum);
			if (rounded > STATE_HI) begin
				rounded = STATE_HI;
				outcome.saturated = 1'b1;
			end else if (rounded < STATE_LO) begin
				rounded = STATE_LO;
				outcome.saturated = 1'b1;
			end
			next_x[i] = rounded[STATE_W-1:0];
		end
		for (i = 0; i < ORDER; i++) begin
			ctl_state[ch][i] = next_x[i];
		end
		return outcome;
	endfunction

	// Appends one error sample to the sender's queue. Most samples follow
	// directly, some after a short pause and a few after a long one.
	task automatic queue_sample(input logic chan, input int err_val, input bit no_gap,
			input bit drain_first);
		queued_sample_t s;
		int pick;
		s.cmd.op = chan;
		s.cmd.error = 16'(err_val);
		s.drain_first = drain_first;
		pick = $urandom_range(0, 99);
		if (no_gap || pick < 60) begin
			s.gap = 0;
		end else if (pick < 90) begin
			s.gap = $urandom_range(1, 3);
		end else begin
			s.gap = $urandom_range(10, 60);
		end
		queued_samples.push_back(s);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sender. The in-flight count is kept from the handshakes seen at each
	// edge, so the decision to hold an item back for a drain does not depend
	// on the order in which the clocked processes run.
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		int flight_now;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data <= '0;
			in_flight <= 0;
			gap_count <= 0;
		end else begin
			flight_now = in_flight + int'(cmd_ch.valid && cmd_ch.ready)
				- int'(res_ch.valid && res_ch.ready);
			in_flight <= flight_now;
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (queued_samples.size() == 0
						|| (queued_samples[0].drain_first && flight_now != 0)) begin
					cmd_ch.valid <= 1'b0;
				end else if (gap_count < queued_samples[0].gap) begin
					cmd_ch.valid <= 1'b0;
					gap_count <= gap_count + 1;
				end else begin
					cmd_ch.valid <= 1'b1;
					cmd_ch.data <= queued_samples[0].cmd;
					void'(queued_samples.pop_front());
					gap_count <= 0;
				end
			end
		end
	end

	// Receiver. Ready drops at random for short and long stretches. Once,
	// after 150 results, it holds off for a long stretch so that the block
	// takes one more item and then stalls its input while the sender keeps
	// offering. A later window of results is taken with no stall at all.
	always @(posedge clk or negedge arst_n) begin : res_acceptor
		int pick;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_count <= 0;
			res_taken <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				res_taken <= res_taken + 1;
			end
			if (hold_count > 0) begin
				res_ch.ready <= 1'b0;
				hold_count <= hold_count - 1;
			end else if (!long_hold_done && res_taken >= 150) begin
				res_ch.ready <= 1'b0;
				hold_count <= LONG_HOLD;
				long_hold_done <= 1'b1;
			end else if (res_taken >= 260 && res_taken < 320) begin
				res_ch.ready <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					res_ch.ready <= 1'b1;
				end else if (pick < 95) begin
					res_ch.ready <= 1'b0;
					hold_count <= $urandom_range(0, 2);
				end else begin
					res_ch.ready <= 1'b0;
					hold_count <= $urandom_range(10, 60);
				end
			end
		end
	end

	// Monitor. Every accepted sample is run through the predictor at the edge
	// where it is taken, and every accepted result is checked against the
	// oldest prediction. Predictions are queued before results are popped.
	always @(posedge clk) begin : res_monitor
		res_t want;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_forces.push_back(advance_controller(cmd_ch.data));
				if (cmd_ch.data.op == YAW) begin
					yaw_items++;
				end else begin
					depth_items++;
				end
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_forces.size() == 0) begin
					$error("result with no sample outstanding: force_res %0d saturated %0b",
						res_ch.data.force_res, res_ch.data.saturated);
					fail_count++;
				end else begin
					want = expected_forces.pop_front();
					results_checked++;
					if (res_ch.data.saturated) begin
						saturated_seen++;
					end
					if (res_ch.data.force_res !== want.force_res) begin
						$error("force_res mismatch: expected %0d, got %0d",
							want.force_res, res_ch.data.force_res);
						fail_count++;
					end
					if (res_ch.data.saturated !== want.saturated) begin
						$error("saturated mismatch: expected %0b, got %0b",
							want.saturated, res_ch.data.saturated);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: a run that goes this long with no handshake on either side
	// is hung, since every correct pause is shorter.
	always @(posedge clk or negedge arst_n) begin : watchdog
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("state_space_controller_step_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic directed_op [22];
		int directed_err [22];
		logic chan;
		logic burst_chan;
		int n_random;
		int burst;
		int style;
		int negative;
		int mag;
		int err_val;
		int k;
		int c;
		int i;

		arst_n = 1'b0;
		fail_count = 0;
		yaw_items = 0;
		depth_items = 0;
		results_checked = 0;
		saturated_seen = 0;
		for (c = 0; c < CHANNELS; c++) begin
			for (i = 0; i < ORDER; i++) begin
				ctl_state[c][i] = '0;
			end
		end

		// Directed part: zero input from the reset state on both channels, the
		// most positive and most negative error, one LSB either way, the two
		// alternating bit patterns, and a run of full-scale error on yaw to
		// push its state toward the clipping limits.
		directed_op = '{YAW, DEPTH, YAW, YAW, YAW, DEPTH, DEPTH, DEPTH, YAW, YAW, DEPTH,
			DEPTH, YAW, DEPTH, YAW, DEPTH, YAW, YAW, YAW, YAW, YAW, YAW};
		directed_err = '{0, 0, 32767, 32767, -32768, -32768, -32768, 32767, 1, -1, 1,
			-1, 21845, -21846, 0, 0, 32767, 32767, 32767, 32767, 32767, 32767};
		for (i = 0; i < 22; i++) begin
			queue_sample(directed_op[i], directed_err[i], 1'b0, 1'b0);
		end

		// Random part, in bursts on one channel with the occasional sample for
		// the other channel mixed in. Half of the bursts hold a large error of one
		// sign so the states wind up; the rest are random, small or extreme.
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			chan = 1'($urandom_range(0, 1));
			burst = $urandom_range(1, 24);
			style = $urandom_range(0, 99);
			negative = $urandom_range(0, 1);
			for (k = 0; k < burst; k++) begin
				if (style < 50) begin
					mag = $urandom_range(16384, 32767);
					err_val = negative ? -mag - 1 : mag;
				end else if (style < 75) begin
					err_val = int'($urandom_range(0, 65535)) - 32768;
				end else if (style < 90) begin
					err_val = int'($urandom_range(0, 64)) - 32;
				end else begin
					err_val = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
				end
				burst_chan = ($urandom_range(0, 7) == 0) ? ~chan : chan;
				// The sender pauses for a full drain at the start of the random
				// part and again in the middle of it; a later stretch has no gaps.
				queue_sample(burst_chan, err_val, n_random >= 260 && n_random < 320,
					n_random == 0 || n_random == 200);
				n_random++;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_samples.size() != 0 || cmd_ch.valid || in_flight != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_forces.size() != 0) begin
			$error("%0d expected results never arrived", expected_forces.size());
			fail_count++;
		end

		$display("Checked %0d controller steps (%0d yaw, %0d depth), %0d of them clipped.",
			results_checked, yaw_items, depth_items, saturated_seen);
		$display("Stimulus mixed full-scale, random and small errors with a long result stall and drain pauses.");
		if (fail_count == 0) begin
			$display("state_space_controller_step_top test passed");
		end else begin
			$display("state_space_controller_step_top test failed");
		end
		$finish;
	end

endmodule
